// ----- sv/mh_pkg.sv -----
// mh_pkg: shared types, widths and constants for the magnetometer heading block.
// Used by every module of the block and by the port checker.
// No dependencies.
package mh_pkg;

    // CORDIC depth (valid range 8..24) and arctangent table length
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int IDX_W         = $clog2(TABLE_LEN);

    // Datapath widths
    localparam int FIELD_W = 16;             // raw axis reading
    localparam int AXIS_W  = FIELD_W + 1;    // north/west after optional negation
    localparam int FRAC_W  = 16;             // fraction bits of the CORDIC x/y
    localparam int XY_W    = 36;             // holds 2.33 * 2^15 growth plus fraction
    localparam int Z_W     = 26;             // angle, degrees q16, about +-190 deg
    localparam int DECL_W  = 15;
    localparam int DIR_W   = 3;
    localparam int TOT_W   = 33;             // arcminutes q16, signed
    localparam int V_W     = 20;             // (total + half) >> 11
    localparam int RECIP_W = 21;
    localparam int PROD_W  = V_W + RECIP_W;
    localparam int HEAD_W  = 16;

    // Axis direction codes
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd0;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd1;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_DECL  = 2'd0;
    localparam logic [1:0] REG_X_DIR = 2'd1;
    localparam logic [1:0] REG_Y_DIR = 2'd2;
    localparam logic [1:0] REG_Z_DIR = 2'd3;

    // Reset values of the configuration registers
    localparam logic [DECL_W-1:0] DECL_RESET  = 15'd0;
    localparam logic [DIR_W-1:0]  X_DIR_RESET = 3'd0;
    localparam logic [DIR_W-1:0]  Y_DIR_RESET = 3'd2;
    localparam logic [DIR_W-1:0]  Z_DIR_RESET = 3'd4;

    // Angle and arcminute constants
    localparam logic signed [Z_W-1:0]    ANGLE_90  = 26'sd5898240;      // 90 * 2^16
    localparam logic signed [DECL_W-1:0] DECL_MAX  = 15'sd10800;
    localparam logic signed [DECL_W-1:0] DECL_MIN  = -15'sd10800;
    localparam logic signed [TOT_W-1:0]  TURN_Q16  = 33'sd1415577600;   // 21600 * 2^16
    localparam logic signed [TOT_W-1:0]  HALF_STEP = 33'sd15360;        // half of 30720
    localparam int                       STEP_SHIFT = 11;               // 30720 = 2^11 * 15
    // divide by 15: floor(v * RECIP_M / 2^RECIP_SHIFT), exact for v < 2^20
    localparam logic [RECIP_W-1:0]       RECIP_M     = 21'd1118482;
    localparam int                       RECIP_SHIFT = 24;

    // atan(2^-i) in degrees q16, rounded to nearest
    localparam logic signed [Z_W-1:0] ATAN_TABLE [TABLE_LEN] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    // Request payloads
    typedef struct packed {
        logic signed [FIELD_W-1:0] field_x;
        logic signed [FIELD_W-1:0] field_y;
        logic signed [FIELD_W-1:0] field_z;
    } in_t;

    typedef struct packed {
        logic [HEAD_W-1:0] heading_deg_q7;
        logic              axis_unmapped;
    } out_t;

    // Data handed from cell to cell
    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic                   zero;      // zero vector: angle forced to 0
        logic                   unmapped;
    } cordic_t;

endpackage

// ----- sv/magnetometer_heading.sv -----
// Magnetometer compass heading: axis mapping, CORDIC atan2, declination, wrap.
// A request passes the front register, the CORDIC cell registers and the back-end stages.
// Throughput: one request per cycle; each CORDIC cell and stage has its own
// register and holds only while its downstream neighbor is full and stalled.
// Reset (aresetn low, synchronous): pipeline empties, registers go to
// declination 0, x north, y west, z up.
module magnetometer_heading import mh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [DECL_W-1:0] cfg_wdata,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data
);

    logic [DECL_W-1:0] decl_reg;
    logic [DIR_W-1:0]  x_dir_reg;
    logic [DIR_W-1:0]  y_dir_reg;
    logic [DIR_W-1:0]  z_dir_reg;

    logic    chain_valid [CORDIC_STAGES+1];
    logic    chain_ready [CORDIC_STAGES+1];
    cordic_t chain_data  [CORDIC_STAGES+1];

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decl_reg  <= DECL_RESET;
            x_dir_reg <= X_DIR_RESET;
            y_dir_reg <= Y_DIR_RESET;
            z_dir_reg <= Z_DIR_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DECL:  decl_reg  <= cfg_wdata;
                REG_X_DIR: x_dir_reg <= cfg_wdata[DIR_W-1:0];
                REG_Y_DIR: y_dir_reg <= cfg_wdata[DIR_W-1:0];
                REG_Z_DIR: z_dir_reg <= cfg_wdata[DIR_W-1:0];
                default: ;
            endcase
        end
    end

    mh_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .x_dir     (x_dir_reg),
        .y_dir     (y_dir_reg),
        .z_dir     (z_dir_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    // row of CORDIC cells, cell i shifts by i
    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
        mh_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .stage_idx (IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    mh_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .decl_raw  (decl_reg),
        .in_valid  (chain_valid[CORDIC_STAGES]),
        .in_ready  (chain_ready[CORDIC_STAGES]),
        .in_data   (chain_data[CORDIC_STAGES]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

// ----- sv/mh_front.sv -----
// mh_front: axis mapping and quadrant pre-rotation, one register stage.
// Depends on mh_pkg.
module mh_front import mh_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [DIR_W-1:0]    x_dir,
    input  logic [DIR_W-1:0]    y_dir,
    input  logic [DIR_W-1:0]    z_dir,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_t                 in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cordic_t             out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // map axes: z first, then y, then x, so x wins on a shared direction
    always_comb begin
        logic [DIR_W-1:0]        dirs [3];
        logic signed [AXIS_W-1:0] vals [3];
        logic signed [AXIS_W-1:0] north;
        logic signed [AXIS_W-1:0] west;
        logic                    has_n;
        logic                    has_w;
        logic signed [XY_W-1:0]  nx;
        logic signed [XY_W-1:0]  wy;
        dirs[0] = z_dir;
        dirs[1] = y_dir;
        dirs[2] = x_dir;
        vals[0] = AXIS_W'(in_data.field_z);
        vals[1] = AXIS_W'(in_data.field_y);
        vals[2] = AXIS_W'(in_data.field_x);
        north = '0;
        west  = '0;
        has_n = 1'b0;
        has_w = 1'b0;
        for (int k = 0; k < 3; k++) begin
            case (dirs[k])
                DIR_NORTH: begin north = vals[k];  has_n = 1'b1; end
                DIR_SOUTH: begin north = -vals[k]; has_n = 1'b1; end
                DIR_WEST:  begin west  = vals[k];  has_w = 1'b1; end
                DIR_EAST:  begin west  = -vals[k]; has_w = 1'b1; end
                default: ;
            endcase
        end

        nx = XY_W'(north) <<< FRAC_W;
        wy = XY_W'(west) <<< FRAC_W;

        // left half plane: rotate by -90 or +90 degrees first
        data_next.x = nx;
        data_next.y = wy;
        data_next.z = '0;
        if (nx < 0) begin
            if (wy >= 0) begin
                data_next.x = wy;
                data_next.y = -nx;
                data_next.z = ANGLE_90;
            end else begin
                data_next.x = -wy;
                data_next.y = nx;
                data_next.z = -ANGLE_90;
            end
        end
        data_next.zero     = (north == '0) && (west == '0);
        data_next.unmapped = !(has_n && has_w);
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/mh_cordic_cell.sv -----
// mh_cordic_cell: one vectoring CORDIC micro-rotation with its own register.
// Depends on mh_pkg (cordic_t, ATAN_TABLE).
module mh_cordic_cell import mh_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] stage_idx,
    input  logic             in_valid,
    output logic             in_ready,
    input  cordic_t          in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output cordic_t          out_data
);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    // drive y toward zero; angle accumulates the applied rotations
    always_comb begin
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        dx = in_data.y >>> stage_idx;
        dy = in_data.x >>> stage_idx;
        data_next = in_data;
        if (in_data.y > 0) begin
            data_next.x = in_data.x + dx;
            data_next.y = in_data.y - dy;
            data_next.z = in_data.z + ATAN_TABLE[stage_idx];
        end else begin
            data_next.x = in_data.x - dx;
            data_next.y = in_data.y + dy;
            data_next.z = in_data.z - ATAN_TABLE[stage_idx];
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- sv/mh_back.sv -----
// mh_back: declination add, turn wrap and scaling to degrees q7 (three stages).
// Depends on mh_pkg.
module mh_back import mh_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [DECL_W-1:0] decl_raw,
    input  logic              in_valid,
    output logic              in_ready,
    input  cordic_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output out_t              out_data
);

    logic                    v1_reg, v2_reg, v3_reg;
    logic                    r1, r2, r3;
    logic signed [TOT_W-1:0] total_reg;
    logic signed [TOT_W-1:0] total_next;
    logic [V_W-1:0]          steps_reg;
    logic [V_W-1:0]          steps_next;
    logic [PROD_W-1:0]       prod_reg;
    logic                    unm1_reg, unm2_reg, unm3_reg;

    // stage 1: angle in arcminutes q16 plus saturated declination
    always_comb begin
        logic signed [DECL_W-1:0] decl;
        logic signed [Z_W-1:0]    ang;
        decl = signed'(decl_raw);
        if (decl > DECL_MAX) begin
            decl = DECL_MAX;
        end else if (decl < DECL_MIN) begin
            decl = DECL_MIN;
        end
        ang = in_data.zero ? '0 : in_data.z;
        total_next = TOT_W'(ang) * 33'sd60 + (TOT_W'(decl) <<< FRAC_W);
    end

    // stage 2: wrap into one turn, clamp, round and drop 2^11
    always_comb begin
        logic signed [TOT_W-1:0] t;
        logic signed [TOT_W-1:0] t_round;
        t = total_reg;
        if (t < 0) begin
            t = t + TURN_Q16;
        end
        if (t > TURN_Q16) begin
            t = t - TURN_Q16;
        end
        if (t < 0) begin
            t = '0;
        end
        if (t > TURN_Q16) begin
            t = TURN_Q16;
        end
        t_round    = t + HALF_STEP;
        steps_next = t_round[STEP_SHIFT +: V_W];
    end

    // valid/ready chain, each stage takes data when it is empty or draining
    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (r1) v1_reg <= in_valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
        end
        if (r1 && in_valid) begin
            total_reg <= total_next;
            unm1_reg  <= in_data.unmapped;
        end
        if (r2 && v1_reg) begin
            steps_reg <= steps_next;
            unm2_reg  <= unm1_reg;
        end
        // stage 3: divide by 15 through the reciprocal product
        if (r3 && v2_reg) begin
            prod_reg <= PROD_W'(steps_reg) * PROD_W'(RECIP_M);
            unm3_reg <= unm2_reg;
        end
    end

    assign out_valid                = v3_reg;
    assign out_data.heading_deg_q7  = prod_reg[RECIP_SHIFT +: HEAD_W];
    assign out_data.axis_unmapped   = unm3_reg;

endmodule

// ----- sv/mh_checker.sv -----
// mh_checker: port-level checks on the magnetometer heading block, with its bind.
// Depends on mh_pkg and on the top level magnetometer_heading.
module mh_checker import mh_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    // pipeline is empty the cycle after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("results pending after reset");

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    // heading never leaves one full turn
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.heading_deg_q7 <= 16'd46080)
        else $error("heading out of range");

    // a draining or empty output leaves the whole chain open for a request
    a_ready_chain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("request blocked with output free");

endmodule

bind magnetometer_heading mh_checker u_mh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/tb.sv -----
// tb: self-checking testbench for magnetometer_heading (compass heading by CORDIC atan2).
// Has its own heading predictor, a directed table, then random phases with random idling.
// Depends on mh_pkg and magnetometer_heading.
module tb;
    import mh_pkg::*;

    localparam int PIPE_DEPTH = CORDIC_STAGES + 4;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int RANDOM_PHASES = 8;
    localparam longint FULL_TURN = 64'd21600 * 64'd65536;

    // atan(2^-i) in degrees with 16 fraction bits
    localparam longint ATAN_STEP_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef enum logic [2:0] {
        AX_NORTH, AX_SOUTH, AX_WEST, AX_EAST, AX_UP, AX_DOWN, AX_SPARE6, AX_SPARE7
    } axis_dir_e;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        logic [1:0]        idx;
        logic [DECL_W-1:0] val;
        in_t               smp;
        logic              typed;
        out_t              want;
    } row_t;

    logic              aclk;
    logic              aresetn;
    logic              cfg_we;
    logic [1:0]        cfg_index;
    logic [DECL_W-1:0] cfg_wdata;
    logic              s_valid;
    logic              s_ready;
    in_t               s_data;
    logic              m_valid;
    logic              m_ready;
    out_t              m_data;

    // Register copies used by the predictor
    logic [DECL_W-1:0] decl_word;
    axis_dir_e         x_dir, y_dir, z_dir;

    out_t pending_headings [$];
    int   err_count;
    bit   idle_on;
    row_t script [];

    magnetometer_heading DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #10 aclk = ~aclk;

    // Hard stop in case the pipeline hangs
    initial begin
        #(20 * 600000);
        $display("FAIL");
        $finish;
    end

    // Route one axis reading to north or west per its direction code
    function automatic void map_axis(input axis_dir_e dir, input longint v,
                                     inout longint north, inout longint west,
                                     inout bit has_north, inout bit has_west);
        case (dir)
            AX_NORTH: begin north = v;  has_north = 1'b1; end
            AX_SOUTH: begin north = -v; has_north = 1'b1; end
            AX_WEST:  begin west = v;   has_west = 1'b1; end
            AX_EAST:  begin west = -v;  has_west = 1'b1; end
            default: ;
        endcase
    endfunction

    // Vectoring CORDIC: atan2(yv, xv) in degrees q16
    function automatic longint cordic_angle(input longint yv, input longint xv);
        longint xs, ys, zs, dx, dy, t;
        xs = xv * 65536;
        ys = yv * 65536;
        zs = 0;
        if (xv == 0 && yv == 0) begin
            return 0;
        end
        // left half plane: rotate by a quarter turn first
        if (xs < 0) begin
            t = xs;
            if (ys >= 0) begin
                xs = ys;  ys = -t; zs = 90 * 65536;
            end else begin
                xs = -ys; ys = t;  zs = -90 * 65536;
            end
        end
        for (int i = 0; i < CORDIC_STAGES && i < 24; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys > 0) begin
                xs += dx; ys -= dy; zs += ATAN_STEP_DEG[i];
            end else begin
                xs -= dx; ys += dy; zs -= ATAN_STEP_DEG[i];
            end
        end
        return zs;
    endfunction

    // Expected heading for one sample under the current register copies
    function automatic out_t predict_heading(input in_t smp);
        longint north, west, decl, total;
        bit     has_north, has_west;
        out_t   res;
        north = 0;
        west = 0;
        has_north = 1'b0;
        has_west = 1'b0;
        // lowest priority first so X wins over Y over Z
        map_axis(z_dir, longint'($signed(smp.field_z)), north, west, has_north, has_west);
        map_axis(y_dir, longint'($signed(smp.field_y)), north, west, has_north, has_west);
        map_axis(x_dir, longint'($signed(smp.field_x)), north, west, has_north, has_west);
        decl = longint'($signed(decl_word));
        if (decl > 10800) decl = 10800;
        if (decl < -10800) decl = -10800;
        total = cordic_angle(west, north) * 60 + decl * 65536;
        if (total < 0) total += FULL_TURN;
        if (total > FULL_TURN) total -= FULL_TURN;
        if (total < 0) total = 0;
        if (total > FULL_TURN) total = FULL_TURN;
        res.heading_deg_q7 = 16'((total + 15360) / 30720);
        res.axis_unmapped = !(has_north && has_west);
        return res;
    endfunction

    // Mostly back to back, sometimes short gaps, rarely long ones
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic in_t random_sample();
        in_t  smp;
        int   r;
        int   corner [5] = '{-32768, -1, 0, 1, 32767};
        r = $urandom_range(0, 99);
        if (r < 70) begin
            smp = in_t'(48'({$urandom(), $urandom()}));
        end else if (r < 82) begin
            smp.field_x = 16'($signed($urandom_range(0, 8)) - 4);
            smp.field_y = 16'($signed($urandom_range(0, 8)) - 4);
            smp.field_z = 16'($signed($urandom_range(0, 8)) - 4);
        end else begin
            smp.field_x = 16'(corner[$urandom_range(0, 4)]);
            smp.field_y = 16'(corner[$urandom_range(0, 4)]);
            smp.field_z = 16'($urandom());
        end
        return smp;
    endfunction

    function automatic row_t sample_row(input int fx, input int fy, input int fz);
        row_t r;
        r = '0;
        r.kind = ROW_SAMPLE;
        r.smp.field_x = 16'(fx);
        r.smp.field_y = 16'(fy);
        r.smp.field_z = 16'(fz);
        return r;
    endfunction

    function automatic row_t known_row(input int fx, input int fy, input int fz,
                                       input int head, input bit unmapped);
        row_t r;
        r = sample_row(fx, fy, fz);
        r.typed = 1'b1;
        r.want.heading_deg_q7 = 16'(head);
        r.want.axis_unmapped = unmapped;
        return r;
    endfunction

    function automatic row_t write_row(input logic [1:0] idx, input int val);
        row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.val = DECL_W'(val);
        return r;
    endfunction

    // Present one request; record its expected heading when it is taken
    task automatic send_request(input in_t smp, input bit typed, input out_t want);
        int gap;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data <= smp;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        pending_headings.push_back(typed ? want : predict_heading(smp));
        gap = idle_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Stop sending and let every outstanding heading come out
    task automatic drain_pipeline();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_headings.size() != 0) @(posedge aclk);
        repeat (PIPE_DEPTH) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [DECL_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_DECL:  decl_word = val;
            REG_X_DIR: x_dir = axis_dir_e'(val[2:0]);
            REG_Y_DIR: y_dir = axis_dir_e'(val[2:0]);
            REG_Z_DIR: z_dir = axis_dir_e'(val[2:0]);
            default: ;
        endcase
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // Per-phase setting: zero and extremes of declination first, then random
    task automatic configure_phase(input int phase);
        int          decl;
        int          n_axis, w_axis;
        logic [2:0]  dirs [3];
        case (phase)
            0: decl = 0;
            1: decl = 10800;
            2: decl = -10800;
            3: decl = 16383;
            4: decl = -16384;
            default: decl = $urandom_range(0, 32767);
        endcase
        if ($urandom_range(0, 9) < 8) begin
            // one axis north/south, another west/east, the third ignored
            n_axis = $urandom_range(0, 2);
            w_axis = (n_axis + $urandom_range(1, 2)) % 3;
            for (int a = 0; a < 3; a++) dirs[a] = 3'(AX_UP) + 3'($urandom_range(0, 3));
            dirs[n_axis] = $urandom_range(0, 1) ? AX_SOUTH : AX_NORTH;
            dirs[w_axis] = $urandom_range(0, 1) ? AX_EAST : AX_WEST;
        end else begin
            for (int a = 0; a < 3; a++) dirs[a] = 3'($urandom_range(0, 7));
        end
        drain_pipeline();
        write_reg(REG_DECL, DECL_W'(decl));
        write_reg(REG_X_DIR, DECL_W'(dirs[0]));
        write_reg(REG_Y_DIR, DECL_W'(dirs[1]));
        write_reg(REG_Z_DIR, DECL_W'(dirs[2]));
    endtask

    // Result side: random stalls on m_ready
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            stall = idle_gap();
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
        end
    end

    // Compare each heading with the oldest expectation
    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_headings.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("unexpected heading %0d unmapped %0b",
                             m_data.heading_deg_q7, m_data.axis_unmapped);
            end else begin
                want = pending_headings.pop_front();
                if (m_data.heading_deg_q7 !== want.heading_deg_q7 ||
                    m_data.axis_unmapped !== want.axis_unmapped) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("heading mismatch: exp %0d/%0b got %0d/%0b",
                                 want.heading_deg_q7, want.axis_unmapped,
                                 m_data.heading_deg_q7, m_data.axis_unmapped);
                end
            end
        end
    end

    initial begin
        out_t none;
        none = '0;
        err_count = 0;
        idle_on = 1'b1;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        decl_word = DECL_RESET;
        x_dir = axis_dir_e'(X_DIR_RESET);
        y_dir = axis_dir_e'(Y_DIR_RESET);
        z_dir = axis_dir_e'(Z_DIR_RESET);

        script = '{
            // reset mapping: x north, y west, z up, no declination
            known_row(0, 0, 0, 0, 1'b0),                   // zero vector
            sample_row(32767, 0, 0),
            sample_row(-32768, 0, 0),
            sample_row(0, 32767, 0),
            sample_row(0, -32768, 0),
            sample_row(32767, 32767, -32768),
            sample_row(-32768, -32768, 32767),
            sample_row(-32768, 32767, 0),
            sample_row(32767, -32768, 0),
            sample_row(-100, 0, 0),                        // due south: +180
            sample_row(-1, -1, 0),
            known_row(0, 0, 32767, 0, 1'b0),               // up axis ignored
            // declination at both limits and saturated beyond them
            write_row(REG_DECL, 10800),
            known_row(0, 0, 0, 23040, 1'b0),
            write_row(REG_DECL, -10800),
            known_row(0, 0, 0, 23040, 1'b0),
            write_row(REG_DECL, 16383),
            known_row(0, 0, 0, 23040, 1'b0),
            write_row(REG_DECL, -16384),
            known_row(0, 0, 0, 23040, 1'b0),
            write_row(REG_DECL, 0),
            // nothing mapped to north or west
            write_row(REG_X_DIR, AX_UP),
            write_row(REG_Y_DIR, AX_DOWN),
            write_row(REG_Z_DIR, AX_SPARE6),
            known_row(123, 456, 789, 0, 1'b1),
            // x south wins over z north, y east
            write_row(REG_X_DIR, AX_SOUTH),
            write_row(REG_Y_DIR, AX_EAST),
            write_row(REG_Z_DIR, AX_NORTH),
            sample_row(1000, -500, 7000),
            // two west axes, no north
            write_row(REG_X_DIR, AX_WEST),
            write_row(REG_Y_DIR, AX_WEST),
            write_row(REG_Z_DIR, AX_EAST),
            sample_row(1000, 2000, 3000),
            // x east, y north, z spare code
            write_row(REG_X_DIR, AX_EAST),
            write_row(REG_Y_DIR, AX_NORTH),
            write_row(REG_Z_DIR, AX_SPARE7),
            sample_row(-20000, 15000, -5),
            sample_row(21845, -21846, 0)
        };

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (script[i]) begin
            if (script[i].kind == ROW_WRITE) begin
                drain_pipeline();
                write_reg(script[i].idx, script[i].val);
            end else begin
                send_request(script[i].smp, script[i].typed, script[i].want);
            end
        end

        // random phases, each under its own register setting
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure_phase(phase);
            idle_on = ($urandom_range(0, 3) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_request(random_sample(), 1'b0, none);
        end

        drain_pipeline();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
